### rtl/core/rss_pkg.sv
// package for range_scan_segmenter
// holds item, job and configuration types and shared constants
// no dependencies
package rss_pkg;

  localparam int READINGS = 64;
  localparam int IDX_W = 6;
  localparam int SLOTS = 64;
  localparam int ROOT_STEPS = 32;

  typedef enum logic [1:0] {
    CFG_JUMP  = 2'd0,
    CFG_FAR   = 2'd1,
    CFG_ANGLE = 2'd2,
    CFG_LIST  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0] reading_index;
    logic             taken;
    logic [15:0]      distance;
    logic signed [31:0] loc_x;
    logic signed [31:0] loc_y;
    logic signed [31:0] loc_z;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic [IDX_W-1:0]   left_index;
    logic [IDX_W-1:0]   right_index;
    logic [15:0]        nearest;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [31:0]        radius;
    logic [31:0]        seg_width;
    logic               near_flag;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic [15:0] jump_limit;
    logic [15:0] far_limit;
    logic [15:0] angle_step;
    logic [6:0]  list_limit;
  } cfg_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic [IDX_W-1:0]   left_index;
    logic [IDX_W-1:0]   right_index;
    logic [IDX_W-1:0]   span;
    logic [15:0]        nearest;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [31:0]        dx;
    logic [31:0]        dy;
    logic [31:0]        dz;
    logic               near_flag;
    logic               overflow;
  } job_t;

endpackage

### rtl/core/rss_front.sv
// front end: accepts readings, tracks segment state, builds jobs
// depends on rss_pkg
module rss_front import rss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     push,
  output job_t     job
);

  logic [15:0]        prev_dist_r;
  logic signed [31:0] prev_loc_r [3];
  logic [IDX_W-1:0]   start_idx_r;
  logic signed [31:0] start_loc_r [3];
  logic [15:0]        nearest_r;
  logic [6:0]         count_r;
  logic               full_r;

  logic               acc;
  logic [15:0]        dd;
  logic               close;
  logic [6:0]         limit;
  logic [6:0]         count_nxt;
  logic signed [31:0] loc [3];
  logic signed [32:0] diff [3];
  logic signed [32:0] csum [3];
  logic [32:0]        dabs [3];

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign loc[0]   = in_data.loc_x;
  assign loc[1]   = in_data.loc_y;
  assign loc[2]   = in_data.loc_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = 33'(start_loc_r[k]) - 33'(loc[k]);
      dabs[k] = diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
      csum[k] = 33'(start_loc_r[k]) + 33'(prev_loc_r[k]);
    end
  end

  assign dd = (prev_dist_r > in_data.distance) ? prev_dist_r - in_data.distance
                                                : in_data.distance - prev_dist_r;
  assign close = (dd > cfg.jump_limit) ||
                 ((READINGS <= SLOTS) && (in_data.reading_index == IDX_W'(READINGS - 1)));
  assign limit = (cfg.list_limit > 7'(SLOTS)) ? 7'(SLOTS) : cfg.list_limit;
  assign count_nxt = count_r + 7'd1;
  assign push = acc && (in_data.reading_index != '0) && !full_r && in_data.taken && close;

  always_comb begin
    job.slot        = count_r[5:0];
    job.left_index  = start_idx_r;
    job.right_index = in_data.reading_index;
    job.span        = (start_idx_r > in_data.reading_index) ?
                      start_idx_r - in_data.reading_index :
                      in_data.reading_index - start_idx_r;
    job.nearest     = nearest_r;
    job.centre_x    = csum[0][32:1];
    job.centre_y    = csum[1][32:1];
    job.centre_z    = csum[2][32:1];
    job.dx          = dabs[0][31:0];
    job.dy          = dabs[1][31:0];
    job.dz          = dabs[2][31:0];
    job.near_flag   = nearest_r < cfg.far_limit;
    job.overflow    = count_nxt >= limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_dist_r <= '0;
      start_idx_r <= '0;
      nearest_r   <= '0;
      count_r     <= '0;
      full_r      <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev_loc_r[k]  <= '0;
        start_loc_r[k] <= '0;
      end
    end else if (acc) begin
      if (in_data.reading_index == '0) begin
        prev_dist_r <= in_data.distance;
        start_idx_r <= '0;
        nearest_r   <= in_data.distance;
        count_r     <= '0;
        full_r      <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          prev_loc_r[k]  <= loc[k];
          start_loc_r[k] <= loc[k];
        end
      end else if (!full_r && in_data.taken) begin
        prev_dist_r <= in_data.distance;
        for (int k = 0; k < 3; k++) prev_loc_r[k] <= loc[k];
        if (close) begin
          start_idx_r <= in_data.reading_index;
          nearest_r   <= in_data.distance;
          count_r     <= count_nxt;
          if (count_nxt >= limit) full_r <= 1'b1;
          for (int k = 0; k < 3; k++) start_loc_r[k] <= loc[k];
        end else if (in_data.distance < nearest_r) begin
          nearest_r <= in_data.distance;
        end
      end
    end
  end

endmodule

### rtl/core/rss_queue.sv
// two-entry job queue between front and back end
// depends on rss_pkg
module rss_queue import rss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t pop_job
);

  job_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/core/rss_back.sv
// back end: squares, iterative root and width product per segment
// depends on rss_pkg
module rss_back import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        pop,
  input  job_t        q_job,
  input  logic [15:0] angle_step,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQ   = 4'b0010,
    S_ROOT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t      state_r;
  job_t        job_r;
  logic [1:0]  cnt_r;
  logic [4:0]  it_r;
  logic [65:0] acc_r;
  logic [65:0] acc_nxt;
  logic [21:0] pw_r;
  logic [37:0] w_r;
  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [31:0] dsel;
  logic [63:0] sq;
  logic [33:0] rem_sh;
  logic [33:0] trial;
  logic        out_valid_r;
  out_item_t   out_r;
  logic        load;

  assign pop       = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign load      = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    case (cnt_r)
      2'd0:    dsel = job_r.dx;
      2'd1:    dsel = job_r.dy;
      default: dsel = job_r.dz;
    endcase
  end

  assign sq      = 64'(dsel) * 64'(dsel);
  assign acc_nxt = acc_r + 66'(sq);
  assign rem_sh  = {rem_r[31:0], rad_r[63:62]};
  assign trial   = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (q_valid) state_r <= S_SQ;
        S_SQ:   if (cnt_r == 2'd2) state_r <= S_ROOT;
        S_ROOT: if (it_r == 5'(ROOT_STEPS - 1)) state_r <= S_DONE;
        S_DONE: if (load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        job_r <= q_job;
        cnt_r <= '0;
        acc_r <= '0;
      end
      S_SQ: begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd0) pw_r <= 22'(job_r.span) * 22'(angle_step);
        if (cnt_r == 2'd1) w_r  <= 38'(pw_r) * 38'(job_r.nearest);
        if (cnt_r == 2'd2) begin
          rad_r  <= acc_nxt[65:2];
          rem_r  <= '0;
          root_r <= '0;
          it_r   <= '0;
        end
      end
      S_ROOT: begin
        rad_r <= {rad_r[61:0], 2'b00};
        it_r  <= it_r + 5'd1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      default: begin
        if (load) begin
          out_r.slot        <= job_r.slot;
          out_r.left_index  <= job_r.left_index;
          out_r.right_index <= job_r.right_index;
          out_r.nearest     <= job_r.nearest;
          out_r.centre_x    <= job_r.centre_x;
          out_r.centre_y    <= job_r.centre_y;
          out_r.centre_z    <= job_r.centre_z;
          out_r.radius      <= root_r;
          out_r.seg_width   <= (|w_r[37:32]) ? '1 : w_r[31:0];
          out_r.near_flag   <= job_r.near_flag;
          out_r.overflow    <= job_r.overflow;
        end
      end
    endcase
  end

endmodule

### rtl/core/range_scan_segmenter.sv
// top level of the range scan segmenter
// depends on rss_pkg, rss_front, rss_queue, rss_back
//
// readings enter on in_valid/in_ready, one transaction per reading
// closed segments leave on out_valid/out_ready, one transaction each
// registers are written on cfg_valid/cfg_ready (always ready), index and data
// index 0 starts a scan; untaken readings and readings after a full list
// produce nothing
// the front end takes one reading per cycle while the two-entry job queue
// has room; each closed segment goes through the back end in order:
// square and accumulate of dx, dy and dz, 32 root steps of the shared
// digit-by-digit unit, one load into the output register
// the back end pops no new segment before it has loaded the last one
// when the receiver stalls the result holds in the output register, the back
// end waits after its next segment, the queue fills, then in_ready drops
// synchronous active-low reset empties the queue and pipeline and restores
// the register reset values
module range_scan_segmenter import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r;
  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic q_valid;
  job_t pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jump_limit <= 16'd128;
      cfg_r.far_limit  <= 16'd2560;
      cfg_r.angle_step <= 16'd1024;
      cfg_r.list_limit <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_JUMP:  cfg_r.jump_limit <= cfg_data;
        CFG_FAR:   cfg_r.far_limit  <= cfg_data;
        CFG_ANGLE: cfg_r.angle_step <= cfg_data;
        CFG_LIST:  cfg_r.list_limit <= cfg_data[6:0];
        default:   cfg_r <= cfg_r;
      endcase
    end
  end

  rss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  rss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_job   (pop_job)
  );

  rss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .pop        (pop),
    .q_job      (pop_job),
    .angle_step (cfg_r.angle_step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
